### design/psst_pkg.sv
// shared types and constants for the prefix sum search tree
`default_nettype none

package psst_pkg;

  localparam int TREE_DEPTH_DEF = 10;
  localparam int IDX_W          = 11;
  localparam int AMT_W          = 32;
  localparam int VAL_W          = 48;
  localparam int QUEUE_DEPTH    = 4;

  typedef enum logic [1:0] {
    OP_SEARCH,
    OP_ADD,
    OP_SKIP
  } op_kind_t;

  typedef struct packed {
    op_kind_t                  kind;
    logic [IDX_W-1:0]          idx;
    logic signed [VAL_W-1:0]   value;
  } item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_ADD_W,
    ST_ADD_UP,
    ST_ADD_DN,
    ST_DONE
  } back_state_t;

endpackage

`default_nettype wire

### design/psst_front.sv
// front end: accepts requests, classifies them and widens the amount
`default_nettype none

module psst_front #(
  parameter int TREE_DEPTH = psst_pkg::TREE_DEPTH_DEF
) (
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_func,
  input  wire logic [psst_pkg::IDX_W-1:0]        in_entry_index,
  input  wire logic signed [psst_pkg::AMT_W-1:0] in_amount,
  input  wire logic                              clear_done,
  input  wire logic                              q_full,
  output logic                                   q_push,
  output psst_pkg::item_t                        q_item
);

  localparam int ENTRY_COUNT = 2 ** (TREE_DEPTH + 1) - 2;

  logic in_range;

  assign in_range = 32'(in_entry_index) < ENTRY_COUNT;
  assign in_ready = clear_done && !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_item.idx   = in_entry_index;
    q_item.value = psst_pkg::VAL_W'(in_amount);
    if (!in_func) begin
      q_item.kind = psst_pkg::OP_SEARCH;
    end else if (in_range) begin
      q_item.kind = psst_pkg::OP_ADD;
    end else begin
      q_item.kind = psst_pkg::OP_SKIP;
    end
  end

endmodule

`default_nettype wire

### design/psst_queue.sv
// short request queue between front end and tree engine
`default_nettype none

module psst_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire psst_pkg::item_t  push_item,
  output logic                  full,
  input  wire logic             pop,
  output psst_pkg::item_t       head,
  output logic                  empty
);

  localparam int QD = psst_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(QD);

  psst_pkg::item_t  mem_r [QD];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [PW:0]      cnt_r;

  assign full  = cnt_r == (PW + 1)'(QD);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### design/psst_back.sv
// tree engine: node and weight memories, search and add walks, result register
`default_nettype none

module psst_back #(
  parameter int TREE_DEPTH = psst_pkg::TREE_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               q_empty,
  input  wire psst_pkg::item_t                    q_head,
  output logic                                    q_pop,
  output logic                                    clear_done,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [psst_pkg::IDX_W-1:0]              out_found_index,
  output logic signed [psst_pkg::VAL_W-1:0]       out_entry_weight,
  output logic signed [psst_pkg::VAL_W-1:0]       out_total_weight
);

  localparam int VAL_W       = psst_pkg::VAL_W;
  localparam int IDX_W       = psst_pkg::IDX_W;
  localparam int NW          = TREE_DEPTH + 1;
  localparam int NODE_COUNT  = 2 ** NW - 1;
  localparam int ENTRY_COUNT = NODE_COUNT - 1;
  localparam int ROOT_NODE   = 2 ** TREE_DEPTH - 1;
  localparam int FIRST_STEP  = 2 ** (TREE_DEPTH - 1);
  localparam int WCNT        = (ENTRY_COUNT < 2 ** IDX_W) ? ENTRY_COUNT : 2 ** IDX_W;
  localparam int WAW         = $clog2(WCNT);
  localparam int EW          = (NW > IDX_W) ? NW : IDX_W;

  // memories
  logic signed [VAL_W-1:0] node_mem [NODE_COUNT];
  logic signed [VAL_W-1:0] wgt_mem  [WCNT];
  logic signed [VAL_W-1:0] node_rd_r;
  logic signed [VAL_W-1:0] wgt_rd_r;

  logic                    node_re;
  logic [NW-1:0]           node_ra;
  logic                    node_we;
  logic [NW-1:0]           node_wa;
  logic signed [VAL_W-1:0] node_wd;
  logic                    wgt_re;
  logic [WAW-1:0]          wgt_ra;
  logic                    wgt_we;
  logic [WAW-1:0]          wgt_wa;
  logic signed [VAL_W-1:0] wgt_wd;

  // control and working registers
  psst_pkg::back_state_t   state_r,      state_nxt;
  logic [NW-1:0]           clr_cnt_r,    clr_cnt_nxt;
  logic [NW-1:0]           j_r,          j_nxt;
  logic [NW-1:0]           cand_r,       cand_nxt;
  logic [NW-1:0]           i_r,          i_nxt;
  logic [TREE_DEPTH-1:0]   step_r,       step_nxt;
  logic signed [VAL_W-1:0] acc_r,        acc_nxt;
  logic signed [VAL_W-1:0] q_r,          q_nxt;
  logic [WAW-1:0]          widx_r,       widx_nxt;
  logic [IDX_W-1:0]        res_found_r,  res_found_nxt;
  logic signed [VAL_W-1:0] res_weight_r, res_weight_nxt;
  logic signed [VAL_W-1:0] total_r,      total_nxt;
  logic                    wb_pend_r,    wb_pend_nxt;
  logic [NW-1:0]           wb_addr_r,    wb_addr_nxt;
  logic signed [VAL_W-1:0] wb_delta_r,   wb_delta_nxt;
  logic                    out_valid_r,  out_valid_nxt;
  logic [IDX_W-1:0]        out_found_r;
  logic signed [VAL_W-1:0] out_weight_r;
  logic signed [VAL_W-1:0] out_total_r;
  logic                    out_load;

  logic [NW-1:0]           step_w;
  logic signed [VAL_W-1:0] node_sum;
  logic signed [VAL_W-1:0] new_wgt;
  logic signed [VAL_W-1:0] neg_q;

  assign step_w   = {1'b0, step_r};
  assign node_sum = acc_r + node_rd_r;
  assign new_wgt  = wgt_rd_r + q_r;
  assign neg_q    = -q_r;

  assign clear_done       = state_r != psst_pkg::ST_CLEAR;
  assign out_valid        = out_valid_r;
  assign out_found_index  = out_found_r;
  assign out_entry_weight = out_weight_r;
  assign out_total_weight = out_total_r;

  // node memory write port: clearing pass or add write-back
  always_comb begin
    node_we = 1'b0;
    node_wa = wb_addr_r;
    node_wd = node_rd_r + wb_delta_r;
    if (state_r == psst_pkg::ST_CLEAR) begin
      node_we = 1'b1;
      node_wa = clr_cnt_r;
      node_wd = '0;
    end else if (wb_pend_r) begin
      node_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    if (node_re) begin
      node_rd_r <= node_mem[node_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (wgt_we) begin
      wgt_mem[wgt_wa] <= wgt_wd;
    end
    if (wgt_re) begin
      wgt_rd_r <= wgt_mem[wgt_ra];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    j_nxt          = j_r;
    cand_nxt       = cand_r;
    i_nxt          = i_r;
    step_nxt       = step_r;
    acc_nxt        = acc_r;
    q_nxt          = q_r;
    widx_nxt       = widx_r;
    res_found_nxt  = res_found_r;
    res_weight_nxt = res_weight_r;
    total_nxt      = total_r;
    wb_pend_nxt    = 1'b0;
    wb_addr_nxt    = wb_addr_r;
    wb_delta_nxt   = wb_delta_r;
    q_pop          = 1'b0;
    node_re        = 1'b0;
    node_ra        = j_r;
    wgt_re         = 1'b0;
    wgt_ra         = WAW'(q_head.idx);
    wgt_we         = 1'b0;
    wgt_wa         = widx_r;
    wgt_wd         = new_wgt;
    out_load       = 1'b0;

    case (state_r)
      psst_pkg::ST_CLEAR: begin
        if (32'(clr_cnt_r) < WCNT) begin
          wgt_we = 1'b1;
          wgt_wa = WAW'(clr_cnt_r);
          wgt_wd = '0;
        end
        if (clr_cnt_r == NW'(NODE_COUNT - 1)) begin
          state_nxt = psst_pkg::ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end

      psst_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          q_nxt    = q_head.value;
          j_nxt    = NW'(ROOT_NODE);
          step_nxt = TREE_DEPTH'(FIRST_STEP);
          case (q_head.kind)
            psst_pkg::OP_SEARCH: begin
              node_re        = 1'b1;
              node_ra        = NW'(ROOT_NODE);
              acc_nxt        = '0;
              cand_nxt       = '0;
              res_weight_nxt = '0;
              state_nxt      = psst_pkg::ST_SEARCH;
            end
            psst_pkg::OP_ADD: begin
              wgt_re        = 1'b1;
              widx_nxt      = WAW'(q_head.idx);
              i_nxt         = NW'(EW'(q_head.idx) + EW'(1));
              res_found_nxt = '0;
              state_nxt     = psst_pkg::ST_ADD_W;
            end
            default: begin
              res_found_nxt  = '0;
              res_weight_nxt = '0;
              state_nxt      = psst_pkg::ST_DONE;
            end
          endcase
        end
      end

      psst_pkg::ST_SEARCH: begin
        if (step_r != '0) begin
          acc_nxt = node_sum;
          if (q_r < node_sum) begin
            j_nxt = j_r - step_w;
          end else begin
            cand_nxt = j_r;
            j_nxt    = j_r + step_w;
          end
          step_nxt = step_r >> 1;
          node_re  = 1'b1;
          node_ra  = j_nxt;
        end else begin
          if (q_r < node_sum) begin
            res_found_nxt = IDX_W'(EW'(cand_r));
          end else begin
            res_found_nxt = IDX_W'(EW'(j_r));
          end
          state_nxt = psst_pkg::ST_DONE;
        end
      end

      psst_pkg::ST_ADD_W: begin
        wgt_we         = 1'b1;
        res_weight_nxt = new_wgt;
        total_nxt      = total_r + q_r;
        state_nxt      = psst_pkg::ST_ADD_UP;
      end

      psst_pkg::ST_ADD_UP: begin
        if (j_r < i_r && step_r != '0) begin
          j_nxt    = j_r + step_w;
          step_nxt = step_r >> 1;
        end else begin
          node_re      = 1'b1;
          node_ra      = j_r;
          wb_pend_nxt  = 1'b1;
          wb_addr_nxt  = j_r;
          wb_delta_nxt = q_r;
          state_nxt    = psst_pkg::ST_ADD_DN;
        end
      end

      psst_pkg::ST_ADD_DN: begin
        if (j_r > i_r && step_r != '0) begin
          j_nxt    = j_r - step_w;
          step_nxt = step_r >> 1;
        end else if (j_r == i_r || step_r == '0) begin
          if (step_r != '0 && j_r == i_r && j_r >= step_w) begin
            node_re      = 1'b1;
            node_ra      = j_r - step_w;
            wb_pend_nxt  = 1'b1;
            wb_addr_nxt  = j_r - step_w;
            wb_delta_nxt = neg_q;
          end
          state_nxt = psst_pkg::ST_DONE;
        end else begin
          node_re      = 1'b1;
          node_ra      = j_r;
          wb_pend_nxt  = 1'b1;
          wb_addr_nxt  = j_r;
          wb_delta_nxt = neg_q;
          state_nxt    = psst_pkg::ST_ADD_UP;
        end
      end

      psst_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = psst_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = psst_pkg::ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psst_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      total_r     <= '0;
      wb_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      total_r     <= total_nxt;
      wb_pend_r   <= wb_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r          <= j_nxt;
    cand_r       <= cand_nxt;
    i_r          <= i_nxt;
    step_r       <= step_nxt;
    acc_r        <= acc_nxt;
    q_r          <= q_nxt;
    widx_r       <= widx_nxt;
    res_found_r  <= res_found_nxt;
    res_weight_r <= res_weight_nxt;
    wb_addr_r    <= wb_addr_nxt;
    wb_delta_r   <= wb_delta_nxt;
    if (out_load) begin
      out_found_r  <= res_found_r;
      out_weight_r <= res_weight_r;
      out_total_r  <= total_r;
    end
  end

  // a node read never meets the write-back of the same node
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (node_re && wb_pend_r) |-> (node_ra != wb_addr_r))
    else $error("node read collides with pending write-back");

  a_wb_from_add: assert property (@(posedge clk) disable iff (!rst_n)
    wb_pend_r |-> ($past(state_r) == psst_pkg::ST_ADD_UP ||
                   $past(state_r) == psst_pkg::ST_ADD_DN))
    else $error("write-back without an add walk");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psst_pkg::ST_CLEAR) |-> (!q_pop && !out_valid_r))
    else $error("activity during clearing pass");

  a_search_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psst_pkg::ST_SEARCH && step_r == '0) |=> (state_r == psst_pkg::ST_DONE))
    else $error("search walk did not finish");

endmodule

`default_nettype wire

### design/prefix_sum_search_tree.sv
// top level of the prefix sum search tree
`default_nettype none

// Weighted-sampling tree over 2^(TREE_DEPTH+1)-2 signed 48-bit weights. A search
// request walks the in-order node array from the root, one node memory read per
// level. An add request updates the weight and total, then walks the tree with
// one index move or one node read-modify-write per cycle. An add to an entry
// beyond the table leaves both memories as they are and returns a zero index and
// weight. Requests queue up in front of the engine, which takes the next one only
// when it is through with the last, and a finished result waits in an output
// register. After reset a clearing pass zeroes both memories; in_ready stays low
// meanwhile.

module prefix_sum_search_tree #(
  parameter int TREE_DEPTH = psst_pkg::TREE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_func,
  input  wire logic [psst_pkg::IDX_W-1:0]        in_entry_index,
  input  wire logic signed [psst_pkg::AMT_W-1:0] in_amount,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [psst_pkg::IDX_W-1:0]             out_found_index,
  output logic signed [psst_pkg::VAL_W-1:0]      out_entry_weight,
  output logic signed [psst_pkg::VAL_W-1:0]      out_total_weight
);

  logic            clear_done;
  logic            q_full;
  logic            q_push;
  psst_pkg::item_t q_item;
  logic            q_pop;
  logic            q_empty;
  psst_pkg::item_t q_head;

  psst_front #(
    .TREE_DEPTH(TREE_DEPTH)
  ) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_entry_index (in_entry_index),
    .in_amount      (in_amount),
    .clear_done     (clear_done),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_item)
  );

  psst_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  psst_back #(
    .TREE_DEPTH(TREE_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .clear_done       (clear_done),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found_index  (out_found_index),
    .out_entry_weight (out_entry_weight),
    .out_total_weight (out_total_weight)
  );

endmodule

`default_nettype wire

### verif/psst_checker.sv
// request/result checker with a built-in prediction of the prefix sum search tree
module psst_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              in_func,
  input  logic [psst_pkg::IDX_W-1:0]        in_entry_index,
  input  logic signed [psst_pkg::AMT_W-1:0] in_amount,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [psst_pkg::IDX_W-1:0]        out_found_index,
  input  logic signed [psst_pkg::VAL_W-1:0] out_entry_weight,
  input  logic signed [psst_pkg::VAL_W-1:0] out_total_weight,
  output int                                fail_count,
  output int                                pending_count,
  output int                                results_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import psst_pkg::*;

  localparam logic FN_SEARCH   = 1'(OP_SEARCH);
  localparam int   DEPTH       = TREE_DEPTH_DEF;
  localparam int   NODE_COUNT  = (1 << (DEPTH + 1)) - 1;
  localparam int   ENTRY_COUNT = NODE_COUNT - 1;
  localparam int   ROOT_NODE   = (1 << DEPTH) - 1;
  localparam int   FIRST_STEP  = 1 << (DEPTH - 1);

  typedef struct packed {
    logic [IDX_W-1:0] found_index;
    logic [VAL_W-1:0] entry_weight;
    logic [VAL_W-1:0] total_weight;
  } tree_result_t;

  logic [VAL_W-1:0] node_sums [NODE_COUNT];
  logic [VAL_W-1:0] weights [ENTRY_COUNT];
  logic [VAL_W-1:0] running_total;
  tree_result_t     expected_results [$];
  int               mismatches;
  int               compared;

  function automatic logic [VAL_W-1:0] node_at(int unsigned j);
    return (j < NODE_COUNT) ? node_sums[j] : '0;
  endfunction

  function automatic void bump_node(int unsigned j, logic [VAL_W-1:0] delta);
    if (j < NODE_COUNT) node_sums[j] = node_sums[j] + delta;
  endfunction

  function automatic logic [IDX_W-1:0] locate_entry(logic signed [VAL_W-1:0] query);
    logic [VAL_W-1:0] acc;
    int unsigned      cand;
    int unsigned      j;
    int unsigned      step;
    acc  = '0;
    cand = 0;
    j    = ROOT_NODE;
    step = FIRST_STEP;
    while (step != 0) begin
      acc = acc + node_at(j);
      if (query < $signed(acc)) begin
        j -= step;
      end else begin
        cand = j;
        j += step;
      end
      step >>= 1;
    end
    acc = acc + node_at(j);
    if (query < $signed(acc)) return cand[IDX_W-1:0];
    return j[IDX_W-1:0];
  endfunction

  function automatic void spread_amount(int unsigned idx, logic [VAL_W-1:0] amt);
    logic [VAL_W-1:0] neg;
    int unsigned      i;
    int unsigned      j;
    int unsigned      step;
    bit               stop;
    neg  = -amt;
    i    = idx + 1;
    j    = ROOT_NODE;
    step = FIRST_STEP;
    stop = 1'b0;
    for (int guard = 0; guard < 2 * DEPTH + 4 && !stop; guard++) begin
      while (j < i && step != 0) begin
        j += step;
        step >>= 1;
      end
      bump_node(j, amt);
      while (j > i && step != 0) begin
        j -= step;
        step >>= 1;
      end
      if (j == i || step == 0) stop = 1'b1;
      else bump_node(j, neg);
    end
    if (step != 0 && j == i && j >= step) bump_node(j - step, neg);
  endfunction

  function automatic tree_result_t apply_request(logic fn, logic [IDX_W-1:0] idx,
                                                 logic [AMT_W-1:0] amt);
    tree_result_t     res;
    logic [VAL_W-1:0] value;
    value = {{(VAL_W - AMT_W){amt[AMT_W-1]}}, amt};
    res   = '0;
    if (fn == FN_SEARCH) begin
      res.found_index = locate_entry(value);
    end else if (idx < ENTRY_COUNT) begin
      running_total = running_total + value;
      weights[idx]  = weights[idx] + value;
      spread_amount(idx, value);
      res.entry_weight = weights[idx];
    end
    res.total_weight = running_total;
    return res;
  endfunction

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    tree_result_t want;
    if (!rst_n) begin
      foreach (node_sums[k]) node_sums[k] = '0;
      foreach (weights[k]) weights[k] = '0;
      running_total = '0;
      expected_results.delete();
      mismatches = 0;
      compared   = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request pending");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          compared++;
          compare_field("found_index", longint'(want.found_index), longint'(out_found_index));
          compare_field("entry_weight", longint'($signed(want.entry_weight)),
                        longint'(out_entry_weight));
          compare_field("total_weight", longint'($signed(want.total_weight)),
                        longint'(out_total_weight));
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(apply_request(in_func, in_entry_index, in_amount));
    end
    fail_count    <= mismatches;
    pending_count <= expected_results.size();
    results_seen  <= compared;
  end

endmodule

### verif/tb_prefix_sum_search_tree.sv
// stimulus, watchdog and verdict for the prefix sum search tree
module tb_prefix_sum_search_tree;
  timeunit 1ns;
  timeprecision 1ps;
  import psst_pkg::*;

  localparam logic FN_SEARCH       = 1'(OP_SEARCH);
  localparam logic FN_ADD          = 1'(OP_ADD);
  localparam int   ENTRY_COUNT     = (1 << (TREE_DEPTH_DEF + 1)) - 2;
  localparam int   RANDOM_REQUESTS = 1028;
  localparam int   STALL_LIMIT     = 10000;
  localparam int   DRAIN_CYCLES    = 64;

  logic                    clk            = 1'b0;
  logic                    rst_n          = 1'b0;
  logic                    in_valid       = 1'b0;
  logic                    in_func        = 1'b0;
  logic [IDX_W-1:0]        in_entry_index = '0;
  logic signed [AMT_W-1:0] in_amount      = '0;
  logic                    out_ready      = 1'b0;
  logic                    in_ready;
  logic                    out_valid;
  logic [IDX_W-1:0]        out_found_index;
  logic signed [VAL_W-1:0] out_entry_weight;
  logic signed [VAL_W-1:0] out_total_weight;

  int     fail_count;
  int     pending_count;
  int     results_seen;
  int     idle_cycles = 0;
  int     n_search    = 0;
  int     n_add       = 0;
  int     n_beyond    = 0;
  bit     in_burst    = 1'b0;
  bit     out_burst   = 1'b0;
  longint weight_shadow [ENTRY_COUNT];

  always #1 clk = ~clk;

  prefix_sum_search_tree dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_entry_index   (in_entry_index),
    .in_amount        (in_amount),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found_index  (out_found_index),
    .out_entry_weight (out_entry_weight),
    .out_total_weight (out_total_weight)
  );

  psst_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_entry_index   (in_entry_index),
    .in_amount        (in_amount),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found_index  (out_found_index),
    .out_entry_weight (out_entry_weight),
    .out_total_weight (out_total_weight),
    .fail_count       (fail_count),
    .pending_count    (pending_count),
    .results_seen     (results_seen)
  );

  task automatic send_request(input logic fn, input logic [IDX_W-1:0] idx,
                              input logic [AMT_W-1:0] amt);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= fn;
    in_entry_index <= idx;
    in_amount      <= amt;
    do @(posedge clk); while (!in_ready);
    if (fn == FN_SEARCH) begin
      n_search++;
    end else begin
      n_add++;
      if (idx < ENTRY_COUNT) weight_shadow[idx] += longint'($signed(amt));
      else n_beyond++;
    end
  endtask

  function automatic longint prefix_below(int k);
    longint sum;
    sum = 0;
    for (int e = 0; e < k; e++) sum += weight_shadow[e];
    return sum;
  endfunction

  function automatic int hot_entry();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return $urandom_range(0, 31);
    if (roll < 8) return $urandom_range(ENTRY_COUNT - 16, ENTRY_COUNT - 1);
    return $urandom_range(0, ENTRY_COUNT - 1);
  endfunction

  function automatic logic [AMT_W-1:0] pick_query();
    int     roll;
    int     off;
    longint q;
    longint total;
    roll = $urandom_range(0, 9);
    if (roll < 6) begin
      off = $urandom_range(0, 2);
      q   = prefix_below(hot_entry()) + off - 1;
    end else if (roll < 8) begin
      total = prefix_below(ENTRY_COUNT);
      q     = (total > 0) ? longint'($urandom) % (total + 1) : 0;
    end else begin
      return $urandom;
    end
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[AMT_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] add_entry();
    if ($urandom_range(0, 19) == 0) return IDX_W'($urandom_range(ENTRY_COUNT, 2**IDX_W - 1));
    return IDX_W'(hot_entry());
  endfunction

  function automatic logic [AMT_W-1:0] add_amount();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 15) return $urandom_range(1, 65536);
    if (roll < 18) return -int'($urandom_range(1, 1000));
    return $urandom;
  endfunction

  initial begin
    int stall;
    int served;
    served = 0;
    forever begin
      if (served % 48 == 0) out_burst = ($urandom_range(0, 3) == 0);
      stall = out_burst ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      served++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    foreach (weight_shadow[k]) weight_shadow[k] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty tree, then extremes of index and amount
    send_request(FN_SEARCH, '0, 32'd0);
    send_request(FN_SEARCH, '1, 32'h7FFF_FFFF);
    send_request(FN_SEARCH, '0, 32'h8000_0000);
    send_request(FN_ADD, 11'd0, 32'd100);
    send_request(FN_ADD, 11'(ENTRY_COUNT - 1), 32'h7FFF_FFFF);
    send_request(FN_ADD, 11'(ENTRY_COUNT), 32'd5);
    send_request(FN_ADD, '1, 32'hFFFF_FFFF);
    send_request(FN_ADD, 11'd1022, 32'd300);
    send_request(FN_ADD, 11'd1023, 32'd200);
    send_request(FN_ADD, 11'd1, 32'h8000_0000);
    send_request(FN_ADD, 11'd1, 32'h7FFF_FFFF);
    send_request(FN_ADD, 11'd1, 32'd1);
    send_request(FN_ADD, 11'd511, 32'hFFFF_FFFF);
    send_request(FN_SEARCH, 11'd5, 32'd0);
    send_request(FN_SEARCH, 11'd0, 32'd99);
    send_request(FN_SEARCH, 11'd0, 32'd100);
    send_request(FN_SEARCH, 11'd0, 32'd101);
    send_request(FN_SEARCH, 11'd0, 32'hFFFF_FFFF);
    send_request(FN_SEARCH, 11'd0, 32'd600);
    send_request(FN_SEARCH, 11'd0, 32'h7FFF_FFFF);
    send_request(FN_SEARCH, 11'd0, 32'h8000_0000);
    send_request(FN_ADD, 11'(ENTRY_COUNT - 1), 32'h8000_0000);
    send_request(FN_SEARCH, 11'd0, 32'h7FFF_FFFF);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 64 == 0) in_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 1) send_request(FN_ADD, add_entry(), add_amount());
      else send_request(FN_SEARCH, IDX_W'($urandom), pick_query());
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d searches and %0d adds (%0d adds beyond the table)",
             n_search, n_add, n_beyond);
    $display("checked %0d results against the predicted tree state", results_seen);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
